// ===== src/fast_sincos_polynomial_unit_macros.svh =====
`ifndef FAST_SINCOS_POLYNOMIAL_UNIT_MACROS_SVH
`define FAST_SINCOS_POLYNOMIAL_UNIT_MACROS_SVH

`define FSPU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define FSPU_ASSERT_SETTLED(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !$past(reset) |-> (prop)) \
      else $error(msg);

`endif

// ===== src/fspu_pkg.sv =====
package fspu_pkg;

   localparam int ANGLE_FRAC_BITS = 24;

   localparam logic [63:0] HALF_PI_Q32 = 64'h0000_0001_921F_B544;

   localparam logic signed [18:0] CO_P7 = -19'sd197193;
   localparam logic signed [24:0] CO_P5 = 25'sd8918886;
   localparam logic signed [28:0] CO_P3 = -29'sd178937260;
   localparam logic signed [30:0] CO_P1 = 31'sd1073738184;

   localparam int ONE_Q16 = 65536;

   localparam int RED_STAGES = 5;
   localparam int POLY_STAGES = 11;
   localparam int STAGES = RED_STAGES + POLY_STAGES;

   typedef struct packed {
      logic [RED_STAGES-1:0]  red;
      logic [POLY_STAGES-1:0] poly;
   } stage_en_type;

   function automatic logic [63:0] half_pi_scaled(input int frac_bits);
      half_pi_scaled = (HALF_PI_Q32 + (64'd1 << (31 - frac_bits))) >> (32 - frac_bits);
   endfunction

endpackage

// ===== src/fspu_ctrl.sv =====
`include "fast_sincos_polynomial_unit_macros.svh"

module fspu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output fspu_pkg::stage_en_type stage_en
);

   localparam int STAGES = fspu_pkg::STAGES;
   localparam int RED_STAGES = fspu_pkg::RED_STAGES;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] en;

   // A stage may load when any stage at or after it is empty or the output is taken.
   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         en[k] = rsp_ready || ((~valid_ff & ({STAGES{1'b1}} << k)) != '0);
      end
      valid_in = (en & {valid_ff[STAGES-2:0], req_valid}) | (~en & valid_ff);
      stage_en.red = en[RED_STAGES-1:0];
      stage_en.poly = en[STAGES-1:RED_STAGES];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   `FSPU_ASSERT_SETTLED(a_occupancy, $countones(valid_ff) == $past($countones(valid_ff)) + $past(int'(req_valid && req_ready)) - $past(int'(rsp_valid && rsp_ready)), "Pipeline word count does not match the handshakes.")
   `FSPU_ASSERT(a_ready_full, !req_ready |-> ((&valid_ff) && !rsp_ready), "Input refused while the pipeline has room.")

endmodule

// ===== src/fspu_reduce.sv =====
module fspu_reduce #(
   parameter int ANGLE_FRAC_BITS = fspu_pkg::ANGLE_FRAC_BITS
) (
   input  logic                              clock,
   input  logic [fspu_pkg::RED_STAGES-1:0]   en,
   input  logic signed [32:0]                arg,
   output logic signed [31:0]                t
);

   localparam int HP_W = ANGLE_FRAC_BITS + 1;
   localparam int Q_W = 32 - ANGLE_FRAC_BITS;
   localparam int RQ_W = 32 + Q_W;
   localparam int QH_W = Q_W + HP_W;
   localparam int T_SHIFT = 30 - ANGLE_FRAC_BITS;
   localparam logic [63:0] HP64 = fspu_pkg::half_pi_scaled(ANGLE_FRAC_BITS);
   localparam logic [63:0] RECIP64 = (64'd1 << 32) / HP64;
   localparam logic [HP_W-1:0] HP = HP64[HP_W-1:0];
   localparam logic [Q_W-1:0] RECIP = RECIP64[Q_W-1:0];

   logic                    neg1_ff, neg1_in;
   logic [31:0]             mag1_ff, mag1_in;
   logic                    neg2_ff;
   logic [31:0]             mag2_ff;
   logic [Q_W-1:0]          q2_ff, q2_in;
   logic [RQ_W-1:0]         rq;
   logic                    neg3_ff;
   logic [31:0]             mag3_ff;
   logic [31:0]             qh3_ff, qh3_in;
   logic [1:0]              qlo3_ff;
   logic [QH_W-1:0]         qh_full;
   logic                    neg4_ff;
   logic [HP_W-1:0]         rem4_ff, rem4_in;
   logic [1:0]              qlo4_ff, qlo4_in;
   logic [31:0]             rem0;
   logic [HP_W:0]           rem0_lo;
   logic                    ge;
   logic signed [31:0]      r5, rn5;
   logic                    flip5;
   logic signed [31:0]      t5_ff, t5_in;

   // The reciprocal estimate of the quarter-turn count is low by at most one.
   always_comb begin
      neg1_in = arg[32];
      mag1_in = arg[32] ? 32'(-arg) : arg[31:0];
      rq = RQ_W'(mag1_ff) * RQ_W'(RECIP);
      q2_in = rq[32 +: Q_W];
      qh_full = QH_W'(q2_ff) * QH_W'(HP);
      qh3_in = qh_full[31:0];
      rem0 = mag3_ff - qh3_ff;
      rem0_lo = rem0[HP_W:0];
      ge = rem0_lo >= {1'b0, HP};
      rem4_in = ge ? HP_W'(rem0_lo - {1'b0, HP}) : rem0_lo[HP_W-1:0];
      qlo4_in = qlo3_ff + {1'b0, ge};
      r5 = qlo4_ff[0] ? 32'(rem4_ff) - 32'(HP) : 32'(rem4_ff);
      flip5 = qlo4_ff[0] ^ qlo4_ff[1] ^ neg4_ff;
      rn5 = flip5 ? -r5 : r5;
      t5_in = rn5 <<< T_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         neg1_ff <= neg1_in;
         mag1_ff <= mag1_in;
      end
      if (en[1]) begin
         neg2_ff <= neg1_ff;
         mag2_ff <= mag1_ff;
         q2_ff <= q2_in;
      end
      if (en[2]) begin
         neg3_ff <= neg2_ff;
         mag3_ff <= mag2_ff;
         qh3_ff <= qh3_in;
         qlo3_ff <= q2_ff[1:0];
      end
      if (en[3]) begin
         neg4_ff <= neg3_ff;
         rem4_ff <= rem4_in;
         qlo4_ff <= qlo4_in;
      end
      if (en[4]) begin
         t5_ff <= t5_in;
      end
   end

   assign t = t5_ff;

endmodule

// ===== src/fspu_poly.sv =====
module fspu_poly (
   input  logic                              clock,
   input  logic [fspu_pkg::POLY_STAGES-1:0]  en,
   input  logic signed [31:0]                t,
   output logic signed [17:0]                result
);

   localparam int S_W = 33;
   localparam int M1_W = 52;
   localparam int M2_W = 59;
   localparam int M3_W = 63;
   localparam int M4_W = 64;
   localparam int A1_W = 26;
   localparam int A2_W = 30;
   localparam int A3_W = 32;
   localparam int A4_W = 32;
   localparam int V_W = 33;
   localparam logic signed [63:0] RND30 = 64'sd536870912;
   localparam logic signed [V_W-1:0] RND14 = 33'sd8192;
   localparam logic signed [V_W-1:0] SAT_HI = V_W'(fspu_pkg::ONE_Q16);
   localparam logic signed [V_W-1:0] SAT_LO = -V_W'(fspu_pkg::ONE_Q16);

   logic signed [31:0]      t_ff [8];
   logic signed [S_W-1:0]   s_ff [5];
   logic signed [63:0]      sq_ff, sq_in, sq_rnd;
   logic signed [S_W-1:0]   s_in;
   logic signed [M1_W-1:0]  m1_ff, m1_in, m1_rnd;
   logic signed [A1_W-1:0]  acc1_ff, acc1_in;
   logic signed [M2_W-1:0]  m2_ff, m2_in, m2_rnd;
   logic signed [A2_W-1:0]  acc2_ff, acc2_in;
   logic signed [M3_W-1:0]  m3_ff, m3_in, m3_rnd;
   logic signed [A3_W-1:0]  acc3_ff, acc3_in;
   logic signed [M4_W-1:0]  m4_ff, m4_in, m4_rnd;
   logic signed [A4_W-1:0]  acc4_ff, acc4_in;
   logic signed [V_W-1:0]   v_rnd, v;
   logic signed [17:0]      res_ff, res_in;

   // Horner's rule in the square of the reduced angle, at most one multiply per stage.
   always_comb begin
      sq_in = 64'(t) * 64'(t);
      sq_rnd = sq_ff + RND30;
      s_in = S_W'(sq_rnd >>> 30);
      m1_in = M1_W'(fspu_pkg::CO_P7) * M1_W'(s_ff[0]);
      m1_rnd = m1_ff + M1_W'(RND30);
      acc1_in = A1_W'((m1_rnd >>> 30) + M1_W'(fspu_pkg::CO_P5));
      m2_in = M2_W'(acc1_ff) * M2_W'(s_ff[2]);
      m2_rnd = m2_ff + M2_W'(RND30);
      acc2_in = A2_W'((m2_rnd >>> 30) + M2_W'(fspu_pkg::CO_P3));
      m3_in = M3_W'(acc2_ff) * M3_W'(s_ff[4]);
      m3_rnd = m3_ff + M3_W'(RND30);
      acc3_in = A3_W'((m3_rnd >>> 30) + M3_W'(fspu_pkg::CO_P1));
      m4_in = M4_W'(acc3_ff) * M4_W'(t_ff[7]);
      m4_rnd = m4_ff + RND30;
      acc4_in = A4_W'(m4_rnd >>> 30);
      v_rnd = V_W'(acc4_ff) + RND14;
      v = v_rnd >>> 14;
      if (v > SAT_HI) begin
         res_in = 18'(SAT_HI);
      end else if (v < SAT_LO) begin
         res_in = 18'(SAT_LO);
      end else begin
         res_in = 18'(v);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         t_ff[0] <= t;
         sq_ff <= sq_in;
      end
      for (int k = 1; k < 8; k++) begin
         if (en[k]) begin
            t_ff[k] <= t_ff[k-1];
         end
      end
      if (en[1]) begin
         s_ff[0] <= s_in;
      end
      for (int j = 1; j < 5; j++) begin
         if (en[j+1]) begin
            s_ff[j] <= s_ff[j-1];
         end
      end
      if (en[2]) begin
         m1_ff <= m1_in;
      end
      if (en[3]) begin
         acc1_ff <= acc1_in;
      end
      if (en[4]) begin
         m2_ff <= m2_in;
      end
      if (en[5]) begin
         acc2_ff <= acc2_in;
      end
      if (en[6]) begin
         m3_ff <= m3_in;
      end
      if (en[7]) begin
         acc3_ff <= acc3_in;
      end
      if (en[8]) begin
         m4_ff <= m4_in;
      end
      if (en[9]) begin
         acc4_ff <= acc4_in;
      end
      if (en[10]) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ===== src/fast_sincos_polynomial_unit.sv =====
// Channel  Dir  Ports                                   Word
// req      in   req_valid req_ready req_angle           angle, Q(31-F).F radians, F fraction bits
// rsp      out  rsp_valid rsp_ready rsp_sine rsp_cosine sine and cosine, Q1.16, saturated to +-1
//
// One word is accepted every cycle while req_ready is high; each path is a 16-stage pipeline.
// Each word passes through five range-reduction stages (abs, reciprocal multiply, back-multiply,
// correct, fold) and eleven polynomial stages, one multiplier or rounding add each.
// Reset clears only the stage valid bits.
// A stalled result holds in the output register while later words close up empty stages;
// req_ready drops only when all sixteen stages hold words.

`include "fast_sincos_polynomial_unit_macros.svh"

module fast_sincos_polynomial_unit #(
   parameter int ANGLE_FRAC_BITS = fspu_pkg::ANGLE_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [17:0] rsp_sine,
   output logic signed [17:0] rsp_cosine
);

   localparam logic [63:0] HP64 = fspu_pkg::half_pi_scaled(ANGLE_FRAC_BITS);

   fspu_pkg::stage_en_type stage_en;
   logic signed [32:0]     arg_sin;
   logic signed [32:0]     arg_cos;
   logic signed [31:0]     t_sin;
   logic signed [31:0]     t_cos;

   // The cosine is the sine of the angle advanced by a quarter turn.
   assign arg_sin = 33'(req_angle);
   assign arg_cos = 33'(req_angle) + 33'(HP64);

   fspu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stage_en  (stage_en)
   );

   fspu_reduce #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_reduce_sin (
      .clock (clock),
      .en    (stage_en.red),
      .arg   (arg_sin),
      .t     (t_sin)
   );

   fspu_reduce #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_reduce_cos (
      .clock (clock),
      .en    (stage_en.red),
      .arg   (arg_cos),
      .t     (t_cos)
   );

   fspu_poly u_poly_sin (
      .clock  (clock),
      .en     (stage_en.poly),
      .t      (t_sin),
      .result (rsp_sine)
   );

   fspu_poly u_poly_cos (
      .clock  (clock),
      .en     (stage_en.poly),
      .t      (t_cos),
      .result (rsp_cosine)
   );

   `FSPU_ASSERT(a_sine_range, rsp_valid |-> (rsp_sine <= 18'sd65536 && rsp_sine >= -18'sd65536), "Sine outside plus or minus one.")
   `FSPU_ASSERT(a_cosine_range, rsp_valid |-> (rsp_cosine <= 18'sd65536 && rsp_cosine >= -18'sd65536), "Cosine outside plus or minus one.")
   `FSPU_ASSERT(a_unit_circle, rsp_valid |-> (rsp_sine >= 18'sd46000 || rsp_sine <= -18'sd46000 || rsp_cosine >= 18'sd46000 || rsp_cosine <= -18'sd46000), "Sine and cosine are both too small.")

endmodule
